// ===== src/exclusion_ring_event_step_unit_assert.svh =====
// assertion macros shared by the event step unit
`ifndef EXCLUSION_RING_EVENT_STEP_UNIT_ASSERT_SVH
`define EXCLUSION_RING_EVENT_STEP_UNIT_ASSERT_SVH

// checked outside reset
`define ERSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define ERSU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/ersu_pkg.sv =====
package ersu_pkg;

  localparam logic [1:0] MODE_TAU   = 2'd0;
  localparam logic [1:0] MODE_PLACE = 2'd1;
  localparam logic [1:0] MODE_STEP  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [7:0]         RING_RESET = 8'd100;
  localparam logic [47:0]        ROUND_HALF = 48'h8000;
  localparam logic signed [31:0] CUR_MIN    = 32'sh8000_0000;
  localparam logic signed [31:0] CUR_MAX    = 32'sh7fff_ffff;

  typedef struct packed {
    logic [1:0]  mode;
    logic [6:0]  slot;
    logic [23:0] tau_value;
    logic [6:0]  position;
    logic [31:0] wait_value;
    logic        direction;
    logic [23:0] exp_sample;
  } item_t;

  typedef struct packed {
    logic [31:0]        elapsed;
    logic [5:0]         particle;
    logic [6:0]         new_position;
    logic               moved;
    logic signed [31:0] current;
  } res_t;

  // one particle entry: site and pending time stored against the running base
  typedef struct packed {
    logic [6:0]  pos;
    logic [31:0] wait_t;
  } pent_t;

  typedef struct packed {
    logic        vld;
    logic [6:0]  site;
    logic [23:0] smp;
  } tau_req_t;

  typedef struct packed {
    logic        we;
    logic [6:0]  site;
    logic [23:0] data;
  } tau_wr_t;

endpackage

// ===== src/ersu_if.sv =====
interface ersu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [6:0]  slot;
  logic [23:0] tau_value;
  logic [6:0]  position;
  logic [31:0] wait_value;
  logic        direction;
  logic [23:0] exp_sample;
  modport source (output valid, mode, slot, tau_value, position, wait_value, direction,
                  exp_sample, input ready);
  modport sink (input valid, mode, slot, tau_value, position, wait_value, direction,
                exp_sample, output ready);
endinterface

interface ersu_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        elapsed;
  logic [5:0]         particle;
  logic [6:0]         new_position;
  logic               moved;
  logic signed [31:0] current;
  modport source (output valid, elapsed, particle, new_position, moved, current,
                  input ready);
  modport sink (input valid, elapsed, particle, new_position, moved, current,
                output ready);
endinterface

interface ersu_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== src/ersu_tau.sv =====
module ersu_tau #(
  parameter int MAX_SITES = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ersu_pkg::tau_wr_t  wr_i,
  input  ersu_pkg::tau_req_t req_i,
  output logic              rsp_vld_o,
  output logic [31:0]       rsp_o
);
  import ersu_pkg::*;

  localparam int SW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;

  logic [23:0] tau_mem [MAX_SITES];
  logic [23:0] tau_rd_q;
  logic        wr_ok, rd_ok;
  logic        v1_q, v2_q, v3_q;
  logic        ok1_q;
  logic [23:0] smp1_q;
  logic [47:0] prod_q;
  logic [47:0] rnd;
  logic [31:0] rsp_q;

  assign wr_ok = 32'(wr_i.site) < MAX_SITES;
  assign rd_ok = 32'(req_i.site) < MAX_SITES;

  always_ff @(posedge clk_i) begin
    if (wr_i.we && wr_ok) tau_mem[SW'(wr_i.site)] <= wr_i.data;
    tau_rd_q <= tau_mem[SW'(req_i.site)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= req_i.vld;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // product fits 48 bits, rounded result always below 2^32
  assign rnd = prod_q + ROUND_HALF;

  always_ff @(posedge clk_i) begin
    ok1_q  <= rd_ok;
    smp1_q <= req_i.smp;
    prod_q <= 48'(ok1_q ? tau_rd_q : 24'd0) * 48'(smp1_q);
    rsp_q  <= rnd[47:16];
  end

  assign rsp_vld_o = v3_q;
  assign rsp_o     = rsp_q;

endmodule

// ===== src/ersu_ctrl.sv =====
`include "exclusion_ring_event_step_unit_assert.svh"

module ersu_ctrl #(
  parameter int PARTICLES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_vld_i,
  output logic               in_rdy_o,
  input  ersu_pkg::item_t     item_i,
  input  logic [7:0]         ring_n_i,
  input  logic               slot_free_i,
  output logic               done_o,
  output ersu_pkg::res_t      res_o,
  output ersu_pkg::tau_req_t  tau_req_o,
  output ersu_pkg::tau_wr_t   tau_wr_o,
  input  logic               tau_rsp_vld_i,
  input  logic [31:0]        tau_rsp_i
);
  import ersu_pkg::*;

  localparam int IW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int CW = $clog2(PARTICLES + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_NBRD   = 3'd2;
  localparam logic [2:0] ST_NBWAIT = 3'd3;
  localparam logic [2:0] ST_TAU    = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  pent_t           mem_q [PARTICLES];
  pent_t           rd_q;
  logic            mem_we;
  logic [IW-1:0]   mem_addr;
  pent_t           mem_wd;

  logic [2:0]         state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [31:0]        base_q, base_d;
  logic signed [31:0] cur_q, cur_d;
  logic [31:0]        min_q, min_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [6:0]         cpos_q, cpos_d;
  logic               dir_q, dir_d;
  logic [23:0]        smp_q, smp_d;
  logic [6:0]         newpos_q, newpos_d;
  logic               moved_q, moved_d;
  logic               step_q, step_d;

  logic [31:0]   eff;
  logic [IW-1:0] nb;
  logic [7:0]    tgt;
  logic          accept;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wd;
    rd_q <= mem_q[mem_addr];
  end

  assign in_rdy_o = (state_q == ST_IDLE);
  assign accept   = in_vld_i && in_rdy_o;
  // stored times are kept relative to base_q, so one add replaces the sweep
  assign eff      = rd_q.wait_t - base_q;

  always_comb begin
    if (!dir_q) nb = (idx_q == '0) ? IW'(PARTICLES - 1) : idx_q - 1'b1;
    else        nb = (idx_q == IW'(PARTICLES - 1)) ? '0 : idx_q + 1'b1;
    if (!dir_q) tgt = (cpos_q == 7'd0) ? ring_n_i - 8'd1 : {1'b0, cpos_q} - 8'd1;
    else        tgt = ({1'b0, cpos_q} >= ring_n_i - 8'd1) ? 8'd0 : {1'b0, cpos_q} + 8'd1;
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    base_d   = base_q;
    cur_d    = cur_q;
    min_d    = min_q;
    idx_d    = idx_q;
    cpos_d   = cpos_q;
    dir_d    = dir_q;
    smp_d    = smp_q;
    newpos_d = newpos_q;
    moved_d  = moved_q;
    step_d   = step_q;
    mem_we   = 1'b0;
    mem_addr = '0;
    mem_wd   = '0;
    tau_req_o = '0;
    tau_wr_o  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          step_d  = 1'b0;
          state_d = ST_DONE;
          case (item_i.mode)
            MODE_TAU: begin
              tau_wr_o.we   = 1'b1;
              tau_wr_o.site = item_i.slot;
              tau_wr_o.data = item_i.tau_value;
            end
            MODE_PLACE: begin
              mem_we      = 32'(item_i.slot) < PARTICLES;
              mem_addr    = IW'(item_i.slot);
              mem_wd.pos    = item_i.position;
              mem_wd.wait_t = item_i.wait_value + base_q;
            end
            MODE_CLEAR: cur_d = '0;
            default: begin
              step_d  = 1'b1;
              dir_d   = item_i.direction;
              smp_d   = item_i.exp_sample;
              cnt_d   = '0;
              state_d = ST_SCAN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // read issued at count c, compared at count c + 1
        if (32'(cnt_q) < PARTICLES) mem_addr = IW'(cnt_q);
        if (cnt_q != '0) begin
          if (cnt_q == CW'(1) || eff < min_q) begin
            min_d  = eff;
            idx_d  = IW'(cnt_q - 1'b1);
            cpos_d = rd_q.pos;
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(PARTICLES)) state_d = ST_NBRD;
      end
      ST_NBRD: begin
        mem_addr = nb;
        state_d  = ST_NBWAIT;
      end
      ST_NBWAIT: begin
        moved_d  = (rd_q.pos != tgt[6:0]);
        newpos_d = moved_d ? tgt[6:0] : cpos_q;
        if (moved_d) begin
          if (!dir_q) begin
            if (cur_q != CUR_MIN) cur_d = cur_q - 32'sd1;
          end else begin
            if (cur_q != CUR_MAX) cur_d = cur_q + 32'sd1;
          end
        end
        base_d         = base_q + min_q;
        tau_req_o.vld  = 1'b1;
        tau_req_o.site = newpos_d;
        tau_req_o.smp  = smp_q;
        state_d        = ST_TAU;
      end
      ST_TAU: begin
        if (tau_rsp_vld_i) begin
          mem_we        = 1'b1;
          mem_addr      = idx_q;
          mem_wd.pos    = newpos_q;
          mem_wd.wait_t = tau_rsp_i + base_q;
          state_d       = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      base_q  <= '0;
      cur_q   <= '0;
      step_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      base_q  <= base_d;
      cur_q   <= cur_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_q    <= min_d;
    idx_q    <= idx_d;
    cpos_q   <= cpos_d;
    dir_q    <= dir_d;
    smp_q    <= smp_d;
    newpos_q <= newpos_d;
    moved_q  <= moved_d;
  end

  assign done_o             = (state_q == ST_DONE) && slot_free_i;
  assign res_o.elapsed      = step_q ? min_q : '0;
  assign res_o.particle     = step_q ? 6'(idx_q) : '0;
  assign res_o.new_position = step_q ? newpos_q : '0;
  assign res_o.moved        = step_q ? moved_q : 1'b0;
  assign res_o.current      = cur_q;

  `ERSU_ASSERT(a_tau_latency, tau_req_o.vld |-> ##3 tau_rsp_vld_i, "tau response late")
  `ERSU_ASSERT(a_no_wr_in_scan, (state_q == ST_SCAN) |-> !mem_we, "write during scan")
  `ERSU_ASSERT_ALWAYS(a_ready_when_idle, (state_q == ST_IDLE) |-> in_rdy_o, "idle but not ready")

endmodule

// ===== src/exclusion_ring_event_step_unit.sv =====
// channel  dir  handshake      content
// in_i     in   valid/ready    mode, slot, tau_value, position, wait_value, direction, sample
// out_o    out  valid/ready    elapsed, particle, new_position, moved, current
// cfg_i    in   valid/ready    ring_length (8 bits)
//
// an event step runs a scan of the particle memory, one entry per
// cycle through its single port, a neighbor read, then the three-stage tau multiply
// other modes pass straight from idle to done; one item is in work at a time, the next
// is taken while the result still waits in the output register
// reset is asynchronous and clears control state and the current; no clearing pass
module exclusion_ring_event_step_unit #(
  parameter int MAX_SITES = 128,
  parameter int PARTICLES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  ersu_in_if.sink    in_i,
  ersu_out_if.source out_o,
  ersu_cfg_if.sink   cfg_i
);
  import ersu_pkg::*;

  localparam int RingCap = (MAX_SITES < 128) ? MAX_SITES : 128;

  logic [7:0] ring_q;
  logic [7:0] ring_n;
  item_t      item;
  res_t       res, res_q;
  logic       done, out_vld_q, slot_free;
  tau_req_t   tau_req;
  tau_wr_t    tau_wr;
  logic       tau_rsp_vld;
  logic [31:0] tau_rsp;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q <= RING_RESET;
    end else if (cfg_i.valid) begin
      ring_q <= cfg_i.data;
    end
  end

  always_comb begin
    if (ring_q < 8'd2)                 ring_n = 8'd2;
    else if (ring_q > 8'(RingCap))     ring_n = 8'(RingCap);
    else                               ring_n = ring_q;
  end

  assign item.mode       = in_i.mode;
  assign item.slot       = in_i.slot;
  assign item.tau_value  = in_i.tau_value;
  assign item.position   = in_i.position;
  assign item.wait_value = in_i.wait_value;
  assign item.direction  = in_i.direction;
  assign item.exp_sample = in_i.exp_sample;

  assign slot_free = !out_vld_q || out_o.ready;

  ersu_ctrl #(.PARTICLES(PARTICLES)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_vld_i     (in_i.valid),
    .in_rdy_o     (in_i.ready),
    .item_i       (item),
    .ring_n_i     (ring_n),
    .slot_free_i  (slot_free),
    .done_o       (done),
    .res_o        (res),
    .tau_req_o    (tau_req),
    .tau_wr_o     (tau_wr),
    .tau_rsp_vld_i(tau_rsp_vld),
    .tau_rsp_i    (tau_rsp)
  );

  ersu_tau #(.MAX_SITES(MAX_SITES)) u_tau (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (tau_wr),
    .req_i    (tau_req),
    .rsp_vld_o(tau_rsp_vld),
    .rsp_o    (tau_rsp)
  );

  // output register, loaded only when its previous transfer is done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= done || (out_vld_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) res_q <= res;
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.elapsed      = res_q.elapsed;
  assign out_o.particle     = res_q.particle;
  assign out_o.new_position = res_q.new_position;
  assign out_o.moved        = res_q.moved;
  assign out_o.current      = res_q.current;

endmodule

// ===== tb/sv/tb_exclusion_ring_event_step_unit.sv =====
`timescale 1ns / 100ps

module tb_exclusion_ring_event_step_unit;
  import ersu_pkg::*;

  localparam int NSITES = 128;
  localparam int NPART  = 16;
  localparam int SETTLE = 40;

  typedef struct {
    item_t it;
    bit    typed;
    res_t  want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ersu_in_if  in_if ();
  ersu_out_if out_if ();
  ersu_cfg_if cfg_if ();

  exclusion_ring_event_step_unit #(
    .MAX_SITES(NSITES),
    .PARTICLES(NPART)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source),
    .cfg_i (cfg_if.sink)
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [23:0]        tau_mem [NSITES];
  logic [6:0]         site_of [NPART];
  logic [31:0]        pending [NPART];
  logic signed [31:0] net_current;
  logic [7:0]         ring_reg;

  res_t pending_results [$];
  row_t directed [$];
  int   n_errors, n_steps, n_moved, n_blocked;
  bit   idle_on, hold_req;

  function automatic res_t step_model(item_t it);
    res_t r;
    int unsigned n, c, nb;
    logic [6:0] p, tgt;
    logic [47:0] prod;
    logic [48:0] rounded;
    r = '0;
    case (it.mode)
      MODE_TAU: tau_mem[it.slot] = it.tau_value;
      MODE_PLACE: begin
        if (it.slot < NPART) begin
          site_of[it.slot] = it.position;
          pending[it.slot] = it.wait_value;
        end
      end
      MODE_CLEAR: net_current = 0;
      default: begin
        n = ring_reg < 2 ? 2 : (ring_reg > NSITES ? NSITES : ring_reg);
        c = 0;
        for (int i = 1; i < NPART; i++) if (pending[i] < pending[c]) c = i;
        r.elapsed = pending[c];
        for (int i = 0; i < NPART; i++) pending[i] -= r.elapsed;
        p = site_of[c];
        if (!it.direction) begin
          tgt = (p == 7'd0) ? 7'(n - 1) : p - 7'd1;
          nb = (c == 0) ? NPART - 1 : c - 1;
        end else begin
          tgt = (p >= n - 1) ? 7'd0 : p + 7'd1;
          nb = (c == NPART - 1) ? 0 : c + 1;
        end
        if (site_of[nb] != tgt) begin
          site_of[c] = tgt;
          r.moved = 1'b1;
          if (!it.direction) begin
            if (net_current != CUR_MIN) net_current -= 1;
          end else begin
            if (net_current != CUR_MAX) net_current += 1;
          end
        end
        r.particle = 6'(c);
        r.new_position = site_of[c];
        prod = 48'(tau_mem[site_of[c]]) * 48'(it.exp_sample);
        rounded = (49'(prod) + 49'(ROUND_HALF)) >> 16;
        pending[c] = (rounded > 49'hFFFF_FFFF) ? 32'hFFFF_FFFF : rounded[31:0];
        n_steps++;
        if (r.moved) n_moved++; else n_blocked++;
      end
    endcase
    r.current = net_current;
    return r;
  endfunction

  function automatic item_t mk(logic [1:0] m, logic [6:0] s, logic [23:0] tv, logic [6:0] ps,
                               logic [31:0] wv, logic d, logic [23:0] es);
    item_t it;
    it.mode = m; it.slot = s; it.tau_value = tv; it.position = ps;
    it.wait_value = wv; it.direction = d; it.exp_sample = es;
    return it;
  endfunction

  task automatic add_row(item_t it, bit typed, res_t want);
    row_t r;
    r.it = it; r.typed = typed; r.want = want;
    directed.push_back(r);
  endtask

  task automatic send(item_t it, bit typed, res_t want);
    res_t r;
    while (idle_on && $urandom_range(99) < 33) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= it.mode;
    in_if.slot       <= it.slot;
    in_if.tau_value  <= it.tau_value;
    in_if.position   <= it.position;
    in_if.wait_value <= it.wait_value;
    in_if.direction  <= it.direction;
    in_if.exp_sample <= it.exp_sample;
    do @(posedge clk_i); while (!in_if.ready);
    r = step_model(it);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_ring(logic [7:0] len);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= len;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    ring_reg = len;
  endtask

  function automatic item_t random_item();
    int unsigned k, n;
    item_t it;
    n = ring_reg < 2 ? 2 : (ring_reg > NSITES ? NSITES : ring_reg);
    it = mk(2'($urandom_range(3)), 7'($urandom), 24'($urandom), 7'($urandom), $urandom,
            1'($urandom), 24'($urandom));
    k = $urandom_range(99);
    if (k < 70) begin
      it.mode = MODE_STEP;
      // keep most pending times moderate so the ordering changes often
      if ($urandom_range(9) != 0) it.exp_sample = 24'($urandom_range(24'h3_0000));
    end else if (k < 78) begin
      it.mode = MODE_TAU;
      if ($urandom_range(3) == 0) it.tau_value = $urandom_range(1) ? 24'hFF_FFFF : 24'd0;
    end else if (k < 95) begin
      it.mode = MODE_PLACE;
      if (k < 92) it.slot = 7'($urandom_range(NPART - 1));
      if ($urandom_range(1)) it.position = 7'($urandom_range(n - 1));
      else if ($urandom_range(1)) it.position = $urandom_range(1) ? 7'd0 : 7'(n - 1);
      if ($urandom_range(1)) it.wait_value = $urandom_range(32'h4_0000);
    end else begin
      it.mode = MODE_CLEAR;
    end
    return it;
  endfunction

  // result side
  initial begin
    int unsigned hold_cnt;
    res_t got, want;
    out_if.ready <= 1'b0;
    hold_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got.elapsed = out_if.elapsed;
        got.particle = out_if.particle;
        got.new_position = out_if.new_position;
        got.moved = out_if.moved;
        got.current = out_if.current;
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected");
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.elapsed !== want.elapsed) begin
            $error("elapsed: expected %h got %h", want.elapsed, got.elapsed); n_errors++;
          end
          if (got.particle !== want.particle) begin
            $error("particle: expected %0d got %0d", want.particle, got.particle); n_errors++;
          end
          if (got.new_position !== want.new_position) begin
            $error("new_position: expected %0d got %0d", want.new_position, got.new_position);
            n_errors++;
          end
          if (got.moved !== want.moved) begin
            $error("moved: expected %b got %b", want.moved, got.moved); n_errors++;
          end
          if (got.current !== want.current) begin
            $error("current: expected %0d got %0d", want.current, got.current); n_errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 300;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= idle_on ? ($urandom_range(99) >= 33) : 1'b1;
      end
    end
  end

  initial begin
    #30_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [7:0] lens [8];
    res_t z;
    item_t it;
    int unsigned ph;
    in_if.valid <= 1'b0;
    in_if.mode <= MODE_CLEAR; in_if.slot <= '0; in_if.tau_value <= '0;
    in_if.position <= '0; in_if.wait_value <= '0; in_if.direction <= 1'b0;
    in_if.exp_sample <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    n_errors = 0; n_steps = 0; n_moved = 0; n_blocked = 0;
    idle_on = 1'b1; hold_req = 1'b0;
    net_current = 0;
    ring_reg = RING_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // typed expectations: non-step items report zeros with the current
    z = '0;
    add_row(mk(MODE_CLEAR, 0, 0, 0, 0, 0, 0), 1, z);
    add_row(mk(MODE_PLACE, 7'd127, 0, 7'd5, 32'h1234, 0, 0), 1, z);
    add_row(mk(MODE_PLACE, 7'd16, 0, 7'd5, 32'h1234, 0, 0), 1, z);
    add_row(mk(MODE_TAU, 7'd127, 24'hFF_FFFF, 0, 0, 0, 0), 1, z);
    // fill every tau entry and every particle before any step
    for (int s = 0; s < NSITES; s++)
      add_row(mk(MODE_TAU, 7'(s), 24'($urandom_range(24'h2_0000)), 0, 0, 0, 0), 0, z);
    for (int p = 0; p < NPART; p++)
      add_row(mk(MODE_PLACE, 7'(p), 0, 7'(p * 6), 32'h10_0000 + 32'(p), 0, 0), 0, z);
    // particle 0 at site 0, left hop wraps to the ring end
    add_row(mk(MODE_PLACE, 0, 0, 7'd0, 32'd0, 0, 0), 0, z);
    add_row(mk(MODE_STEP, 0, 0, 0, 0, 1'b0, 24'h01_0000), 0, z);
    // right hop from beyond the ring lands on site 0
    add_row(mk(MODE_PLACE, 7'd3, 0, 7'd127, 32'd0, 0, 0), 0, z);
    add_row(mk(MODE_STEP, 0, 0, 0, 0, 1'b1, 24'hFF_FFFF), 0, z);
    // blocked hop: neighbor index already holds the target site
    add_row(mk(MODE_PLACE, 7'd5, 0, 7'd40, 32'd0, 0, 0), 0, z);
    add_row(mk(MODE_PLACE, 7'd6, 0, 7'd41, 32'hFFFF_FFFF, 0, 0), 0, z);
    add_row(mk(MODE_STEP, 0, 0, 0, 0, 1'b1, 24'd0), 0, z);
    add_row(mk(MODE_PLACE, 7'd4, 0, 7'd39, 32'hFFFF_FFFF, 0, 0), 0, z);
    add_row(mk(MODE_STEP, 0, 0, 0, 0, 1'b0, 24'd0), 0, z);
    // tau max written at site 50, then steps with sample max and small samples
    add_row(mk(MODE_TAU, 7'd50, 24'hFF_FFFF, 0, 0, 0, 0), 0, z);
    add_row(mk(MODE_PLACE, 7'd15, 0, 7'd49, 32'd0, 0, 0), 0, z);
    add_row(mk(MODE_STEP, 0, 0, 0, 0, 1'b1, 24'hFF_FFFF), 0, z);
    add_row(mk(MODE_STEP, 0, 0, 0, 0, 1'b0, 24'h00_0001), 0, z);
    add_row(mk(MODE_STEP, 0, 0, 0, 0, 1'b1, 24'h00_8000), 0, z);
    add_row(mk(MODE_CLEAR, 0, 0, 0, 0, 0, 0), 1, z);

    foreach (directed[i]) send(directed[i].it, directed[i].typed, directed[i].want);
    drain();

    lens = '{8'd2, 8'd128, 8'd0, 8'd1, 8'd255, 8'd17, 8'd100, 8'd3};
    for (ph = 0; ph < 8; ph++) begin
      write_ring(ph == 7 ? 8'($urandom_range(255)) : lens[ph]);
      for (int k = 0; k < 190; k++) begin
        idle_on = !(ph == 3 && k >= 40 && k < 160);
        if (ph == 5 && k == 20) hold_req = 1'b1;
        it = random_item();
        send(it, 0, z);
      end
      drain();
    end

    $display("ran %0d step events (%0d hops, %0d blocked) over 8 ring settings",
             n_steps, n_moved, n_blocked);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/ersu_pkg.sv
src/ersu_if.sv
src/ersu_tau.sv
src/ersu_ctrl.sv
src/exclusion_ring_event_step_unit.sv
tb/sv/tb_exclusion_ring_event_step_unit.sv
